FILE: sv/vmd_pkg.sv
// ----------------------------------------------------------------------------
// vmd_pkg
// Shared types and constants for the vibrato modulated delay block.
// ----------------------------------------------------------------------------
package vmd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH = 2'd2;

  localparam int DL_W = 9;
  localparam int TL_W = 11;
  localparam int MD_W = 17;
  localparam logic [DL_W-1:0] DL_RESET = 9'd256;
  localparam logic [TL_W-1:0] TL_RESET = 11'd1024;
  localparam logic [MD_W-1:0] MD_RESET = 17'd65536;
  localparam logic [MD_W-1:0] DEPTH_FULL = 17'd65536;

  // Item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam int SAMP_W = 16;
  localparam int TVAL_W = 24;
  localparam int TADDR_W = 10;
  localparam int CH_FIELD_W = 3;

  // depth (Q1.16) x entry (Q8.16) = Q9.32
  localparam int PROD_W = MD_W + TVAL_W;
  localparam int FRAC_LSB = 16;
  localparam int OFF_LSB = 32;
  localparam int OFF_W = PROD_W - OFF_LSB;
  localparam int OFFC_W = $clog2(OFF_W);

  // frac (unsigned 16) x difference (signed 17)
  localparam int DIFF_W = SAMP_W + 1;
  localparam int PP_W = 2 * DIFF_W;

  typedef struct packed {
    logic                     cmd;
    logic [CH_FIELD_W-1:0]    channel;
    logic [TADDR_W-1:0]       table_addr;
    logic [TVAL_W-1:0]        table_value;
    logic signed [SAMP_W-1:0] sample_in;
  } vmd_in_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] sample_out;
    logic [CH_FIELD_W-1:0]    out_channel;
  } vmd_out_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_TRD,
    S_MUL,
    S_MOD,
    S_IDX,
    S_RD1,
    S_RD2,
    S_INT,
    S_OUT
  } vmd_state_e;

  // controller -> datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic mul;
    logic mod_step;
    logic idx;
    logic rd1;
    logic rd2;
    logic interp;
    logic out_load;
  } vmd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic is_sample;
    logic mod_done;
  } vmd_sts_t;

endpackage

FILE: sv/vibrato_modulated_delay.sv
// ----------------------------------------------------------------------------
// vibrato_modulated_delay
// Sample word: states S_TRD to S_OUT run before output valid; no new word is
// taken until S_IDLE, and S_OUT waits while the output is held. The offset
// modulo unit (one remainder bit per cycle) and the two sequential delay RAM
// reads lie on this path. Table load words and words for absent channels are
// taken in S_IDLE with no result. After reset a clearing pass zeroes the
// delay RAM; no word is taken meanwhile, config writes always are.
// ----------------------------------------------------------------------------
module vibrato_modulated_delay
  import vmd_pkg::*;
#(
  parameter int CHANNELS = 2,
  parameter int DELAY_DEPTH = 256,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  vmd_in_t               in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output vmd_out_t              out_word_o
);

  vmd_cmd_t cmd;
  vmd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  vmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vmd_dpath #(
    .CHANNELS    (CHANNELS),
    .DELAY_DEPTH (DELAY_DEPTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: sv/vmd_ram.sv
// ----------------------------------------------------------------------------
// vmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/vmd_ctrl.sv
// ----------------------------------------------------------------------------
// vmd_ctrl
// Sequencer: clearing pass, item intake, per-sample step order, result word.
// ----------------------------------------------------------------------------
module vmd_ctrl
  import vmd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  vmd_sts_t sts_i,
  output vmd_cmd_t cmd_o
);

  vmd_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (sts_i.clr_done) state_d = S_IDLE;
      S_IDLE: if (in_valid_i && sts_i.is_sample) state_d = S_TRD;
      S_TRD:  state_d = S_MUL;
      S_MUL:  state_d = S_MOD;
      S_MOD:  if (sts_i.mod_done) state_d = S_IDX;
      S_IDX:  state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_INT;
      S_INT:  state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_CLR:  cmd_o.clr = 1'b1;
      S_IDLE: cmd_o.accept = in_valid_i;
      S_MUL:  cmd_o.mul = 1'b1;
      S_MOD:  cmd_o.mod_step = 1'b1;
      S_IDX:  cmd_o.idx = 1'b1;
      S_RD1:  cmd_o.rd1 = 1'b1;
      S_RD2:  cmd_o.rd2 = 1'b1;
      S_INT:  cmd_o.interp = 1'b1;
      S_OUT:  cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts_i.is_sample) |=> !in_ready_o)
    else $error("input taken while a sample is in flight");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> out_valid_q)
    else $error("finished sample did not reach the output register");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !out_valid_q)
    else $error("result pending during clearing pass");

endmodule

FILE: sv/vmd_dpath.sv
// ----------------------------------------------------------------------------
// vmd_dpath
// Datapath: config registers, positions, table and delay RAMs, multiply,
// offset modulo unit and linear interpolation.
// ----------------------------------------------------------------------------
module vmd_dpath
  import vmd_pkg::*;
#(
  parameter int CHANNELS = 2,
  parameter int DELAY_DEPTH = 256,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  vmd_in_t               in_word_i,
  output vmd_out_t              out_word_o,
  input  vmd_cmd_t              cmd_i,
  output vmd_sts_t              sts_o
);

  localparam int PW = $clog2(DELAY_DEPTH);
  localparam int LW = $clog2(DELAY_DEPTH + 1);
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DDEPTH = CHANNELS << PW;
  localparam int DAW = $clog2(DDEPTH);
  localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TLW = $clog2(TABLE_DEPTH + 1);

  // ---------------- configuration ----------------
  logic [DL_W-1:0] dl_q;
  logic [TL_W-1:0] tl_q;
  logic [MD_W-1:0] md_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_q <= DL_RESET;
      tl_q <= TL_RESET;
      md_q <= MD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DELAY_LENGTH: dl_q <= cfg_data_i[DL_W-1:0];
        REG_TABLE_LENGTH: tl_q <= cfg_data_i[TL_W-1:0];
        REG_MOD_DEPTH:    md_q <= cfg_data_i[MD_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0]   len_c;
  logic [TLW-1:0]  tlen_c;
  logic [MD_W-1:0] depth_c;

  always_comb begin
    if (32'(dl_q) < 32'd2) begin
      len_c = LW'(2);
    end else if (32'(dl_q) > DELAY_DEPTH) begin
      len_c = LW'(DELAY_DEPTH);
    end else begin
      len_c = LW'(dl_q);
    end
    if (tl_q == '0) begin
      tlen_c = TLW'(1);
    end else if (32'(tl_q) > TABLE_DEPTH) begin
      tlen_c = TLW'(TABLE_DEPTH);
    end else begin
      tlen_c = TLW'(tl_q);
    end
    depth_c = (md_q > DEPTH_FULL) ? DEPTH_FULL : md_q;
  end

  // ---------------- item decode ----------------
  logic           ch_ok, is_sample, tab_we;
  logic [CHW-1:0] ch_in;

  assign ch_ok     = 32'(in_word_i.channel) < CHANNELS;
  assign is_sample = (in_word_i.cmd == CMD_SAMPLE) && ch_ok;
  assign ch_in     = in_word_i.channel[CHW-1:0];
  assign tab_we    = cmd_i.accept && (in_word_i.cmd == CMD_LOAD)
                     && (32'(in_word_i.table_addr) < TABLE_DEPTH);

  // ---------------- per-channel positions ----------------
  logic [PW-1:0]  wp_r [CHANNELS];
  logic [TAW-1:0] tp_r [CHANNELS];
  logic [PW-1:0]  wp_cur;
  logic [TAW-1:0] tp_cur;

  assign wp_cur = (32'(wp_r[ch_in]) >= 32'(len_c)) ? '0 : wp_r[ch_in];
  assign tp_cur = (32'(tp_r[ch_in]) >= 32'(tlen_c)) ? '0 : tp_r[ch_in];

  // item registers
  logic [CHW-1:0]           ch_q;
  logic signed [SAMP_W-1:0] samp_q;
  logic [PW-1:0]            wp_q;
  logic [TAW-1:0]           tp_q;
  logic [LW-1:0]            len_q;
  logic [TLW-1:0]           tlen_q;
  logic [MD_W-1:0]          depth_q;

  logic [PW-1:0]  wp_nxt;
  logic [TAW-1:0] tp_nxt;

  assign wp_nxt = (32'(wp_q) + 32'd1 >= 32'(len_q)) ? '0 : PW'(32'(wp_q) + 32'd1);
  assign tp_nxt = (32'(tp_q) + 32'd1 >= 32'(tlen_q)) ? '0 : TAW'(32'(tp_q) + 32'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c] <= '0;
        tp_r[c] <= '0;
      end
    end else if (cmd_i.interp) begin
      wp_r[ch_q] <= wp_nxt;
      tp_r[ch_q] <= tp_nxt;
    end
  end

  // ---------------- modulation table ----------------
  logic [TVAL_W-1:0] tab_rdata;

  vmd_ram #(
    .WIDTH (TVAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (TAW'(in_word_i.table_addr)),
    .wdata_i (in_word_i.table_value),
    .raddr_i (tp_q),
    .rdata_o (tab_rdata)
  );

  // ---------------- delay store ----------------
  logic [DAW-1:0]    clr_q;
  logic [PW-1:0]     i1_q, i2;
  logic              d_we;
  logic [DAW-1:0]    d_waddr, d_raddr;
  logic [SAMP_W-1:0] d_wdata, d_rdata;

  assign i2 = (32'(i1_q) + 32'd1 >= 32'(len_q)) ? '0 : PW'(32'(i1_q) + 32'd1);

  assign d_we    = cmd_i.clr || cmd_i.interp;
  assign d_waddr = cmd_i.clr ? clr_q : DAW'({ch_q, wp_q});
  assign d_wdata = cmd_i.clr ? '0 : samp_q;
  assign d_raddr = cmd_i.rd1 ? DAW'({ch_q, i1_q}) : DAW'({ch_q, i2});

  vmd_ram #(
    .WIDTH (SAMP_W),
    .DEPTH (DDEPTH)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // ---------------- arithmetic ----------------
  logic [PROD_W-1:0]     prod_w, prod_q;
  logic [OFF_W-1:0]      dvd;
  logic [OFFC_W-1:0]     cnt_q;
  logic [LW-1:0]         rem_q;
  logic [LW:0]           rem_sh;
  logic [LW:0]           sum_i1;
  logic signed [DIFF_W-1:0] diff, frac_s;
  logic signed [PP_W-1:0]   pp_w, pp_q;
  logic signed [SAMP_W-1:0] s1_q, s2;
  logic signed [PP_W-FRAC_LSB-1:0] step_v, res_w;

  assign prod_w = depth_q * tab_rdata;
  assign dvd    = prod_q[PROD_W-1:OFF_LSB];
  // restoring remainder, one dividend bit per cycle, MSB first
  assign rem_sh = {rem_q, dvd[OFFC_W'(OFF_W - 1) - cnt_q]};
  assign sum_i1 = (LW+1)'(wp_q) + (LW+1)'(rem_q);

  assign s2     = signed'(d_rdata);
  assign diff   = DIFF_W'(s2) - DIFF_W'(s1_q);
  assign frac_s = signed'({1'b0, prod_q[OFF_LSB-1:FRAC_LSB]});
  assign pp_w   = frac_s * diff;

  // floor(pp / 65536) is an arithmetic shift
  assign step_v = pp_q[PP_W-1:FRAC_LSB];
  assign res_w  = (PP_W-FRAC_LSB)'(s1_q) + step_v;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_sample) begin
      ch_q    <= ch_in;
      samp_q  <= in_word_i.sample_in;
      wp_q    <= wp_cur;
      tp_q    <= tp_cur;
      len_q   <= len_c;
      tlen_q  <= tlen_c;
      depth_q <= depth_c;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_w;
      rem_q  <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.mod_step) begin
      rem_q <= (rem_sh >= {1'b0, len_q}) ? LW'(rem_sh - {1'b0, len_q}) : LW'(rem_sh);
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.idx) begin
      i1_q <= (sum_i1 >= {1'b0, len_q}) ? PW'(sum_i1 - {1'b0, len_q}) : PW'(sum_i1);
    end
    if (cmd_i.rd2) begin
      s1_q <= signed'(d_rdata);
    end
    if (cmd_i.interp) begin
      pp_q <= pp_w;
    end
    if (cmd_i.out_load) begin
      out_word_o.sample_out  <= res_w[SAMP_W-1:0];
      out_word_o.out_channel <= CH_FIELD_W'(ch_q);
    end
  end

  assign sts_o.clr_done  = (clr_q == DAW'(DDEPTH - 1));
  assign sts_o.is_sample = is_sample;
  assign sts_o.mod_done  = (cnt_q == OFFC_W'(OFF_W - 1));

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mod_step |-> (rem_q < len_q))
    else $error("modulo remainder out of range");

  a_tap_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd1 |-> (LW'(i1_q) < len_q))
    else $error("delay tap index beyond delay length");

  a_wp_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.interp |-> (LW'(wp_q) < len_q))
    else $error("write position beyond delay length");

endmodule

FILE: tb/vmd_checker.sv
// ----------------------------------------------------------------------------
// vmd_checker
// Watches the config, input and output channels of the vibrato delay block.
// Keeps its own copy of the delay lines, positions, modulation table and
// registers, predicts each output word and compares it field by field.
// ----------------------------------------------------------------------------
module vmd_checker
  import vmd_pkg::*;
#(
  parameter int CHANNELS = 2,
  parameter int DELAY_DEPTH = 256,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  vmd_in_t               in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  vmd_out_t              out_word_i,
  output int                    pending_o,
  output int                    errors_o
);

  logic [DL_W-1:0] dly_len_q;
  logic [TL_W-1:0] tab_len_q;
  logic [MD_W-1:0] depth_q;

  logic signed [SAMP_W-1:0] dly_line [CHANNELS*DELAY_DEPTH];
  int unsigned              wr_pos   [CHANNELS];
  int unsigned              tab_pos  [CHANNELS];
  logic [TVAL_W-1:0]        mod_tab  [TABLE_DEPTH];

  vmd_out_t vibrato_q[$];

  initial errors_o = 0;
  initial pending_o = 0;

  task automatic report_mismatch(input string msg);
    $display("vmd_checker @%0t: %s", $time, msg);
    errors_o++;
  endtask

  function automatic int unsigned clamp_len(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Applies one accepted input word; queues the expected output for samples.
  function automatic void vibrato_step(input vmd_in_t w);
    int unsigned       len, tlen, wp, tp, off, i1, i2, base;
    longint unsigned   depth, prod;
    longint            s1, s2, frac, mix;
    vmd_out_t          res;
    if (w.cmd == CMD_LOAD) begin
      if (w.table_addr < TABLE_DEPTH) mod_tab[w.table_addr] = w.table_value;
      return;
    end
    if (w.channel >= CHANNELS) return;

    len   = clamp_len(dly_len_q, 2, DELAY_DEPTH);
    tlen  = clamp_len(tab_len_q, 1, TABLE_DEPTH);
    depth = clamp_len(depth_q, 0, DEPTH_FULL);

    // positions left over from a longer setting restart at zero
    wp = wr_pos[w.channel];
    if (wp >= len) wp = 0;
    tp = tab_pos[w.channel];
    if (tp >= tlen) tp = 0;

    prod = depth * longint'(mod_tab[tp]);
    off  = int'((prod >> OFF_LSB) % len);
    frac = longint'((prod >> FRAC_LSB) & 64'hFFFF);

    tp++;
    if (tp >= tlen) tp = 0;

    base = w.channel * DELAY_DEPTH;
    i1 = (wp + off) % len;
    i2 = i1 + 1;
    if (i2 >= len) i2 = 0;

    s1  = dly_line[base + i1];
    s2  = dly_line[base + i2];
    mix = s1 + ((frac * (s2 - s1)) >>> 16);

    dly_line[base + wp] = w.sample_in;
    wp++;
    if (wp >= len) wp = 0;
    wr_pos[w.channel]  = wp;
    tab_pos[w.channel] = tp;

    res.sample_out  = mix[SAMP_W-1:0];
    res.out_channel = w.channel;
    vibrato_q.push_back(res);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vmd_out_t want;
    if (!rst_ni) begin
      dly_len_q = DL_RESET;
      tab_len_q = TL_RESET;
      depth_q   = MD_RESET;
      foreach (dly_line[i]) dly_line[i] = '0;
      foreach (mod_tab[i]) mod_tab[i] = '0;
      foreach (wr_pos[i]) begin
        wr_pos[i]  = 0;
        tab_pos[i] = 0;
      end
      vibrato_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (vibrato_q.size() == 0) begin
          report_mismatch($sformatf("output word ch %0d sample %0d with none expected",
                                    out_word_i.out_channel, out_word_i.sample_out));
        end else begin
          want = vibrato_q.pop_front();
          if (out_word_i.sample_out !== want.sample_out)
            report_mismatch($sformatf("sample_out %0d, expected %0d (ch %0d)",
                                      out_word_i.sample_out, want.sample_out,
                                      want.out_channel));
          if (out_word_i.out_channel !== want.out_channel)
            report_mismatch($sformatf("out_channel %0d, expected %0d",
                                      out_word_i.out_channel, want.out_channel));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DELAY_LENGTH: dly_len_q = cfg_data_i[DL_W-1:0];
          REG_TABLE_LENGTH: tab_len_q = cfg_data_i[TL_W-1:0];
          REG_MOD_DEPTH:    depth_q   = cfg_data_i[MD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) vibrato_step(in_word_i);
    end
    pending_o = vibrato_q.size();
  end

endmodule

FILE: tb/tb_vibrato_modulated_delay.sv
// ----------------------------------------------------------------------------
// tb_vibrato_modulated_delay
// Drives directed and random table loads and samples through a range of
// delay length, table length and depth settings, with random gaps on both
// sides, a long output hold-off and a full drain; a checker compares words.
// ----------------------------------------------------------------------------
module tb_vibrato_modulated_delay;
  import vmd_pkg::*;

  localparam int NCH = 2;
  localparam int DDEP = 256;
  localparam int TDEP = 1024;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 43;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_CH = (1 << CH_FIELD_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DELAY_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  vmd_in_t               in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  vmd_out_t              out_word;

  int errors, pending;
  bit written [TDEP];
  int tab_len_eff = TDEP;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int stall_cnt = 0;
  int idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  vibrato_modulated_delay #(
    .CHANNELS    (NCH),
    .DELAY_DEPTH (DDEP),
    .TABLE_DEPTH (TDEP)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  vmd_checker #(
    .CHANNELS    (NCH),
    .DELAY_DEPTH (DDEP),
    .TABLE_DEPTH (TDEP)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // output side: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      out_ready = 1'b0;
      hold_cnt--;
    end else if (stall_cnt > 0) begin
      out_ready = 1'b0;
      stall_cnt--;
    end else begin
      out_ready = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_cnt = gap_len();
    end
  end

  always @(posedge clk_i) begin
    if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_vibrato_modulated_delay: errors");
      $finish;
    end
  end

  function automatic vmd_in_t junk_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(vmd_in_t)-1:0];
  endfunction

  function automatic logic signed [SAMP_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7FFF;
    return $urandom();
  endfunction

  // valid stays high after the word is taken; the next send or gap decides
  task automatic send_word(input vmd_in_t w);
    int n;
    in_word  = w;
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    n = quiet ? 0 : gap_len();
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_load(input int unsigned addr, input logic [TVAL_W-1:0] value);
    vmd_in_t w;
    w = junk_word();
    w.cmd         = CMD_LOAD;
    w.table_addr  = addr;
    w.table_value = value;
    written[addr] = 1'b1;
    send_word(w);
  endtask

  task automatic send_sample(input int unsigned ch, input logic signed [SAMP_W-1:0] s);
    vmd_in_t w;
    w = junk_word();
    w.cmd       = CMD_SAMPLE;
    w.channel   = ch;
    w.sample_in = s;
    send_word(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // junk above the register width must be dropped by the block
  task automatic configure(input logic [DL_W-1:0] dl, input logic [TL_W-1:0] tl,
                           input logic [MD_W-1:0] md);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom();
    data[DL_W-1:0] = dl;
    write_reg(REG_DELAY_LENGTH, data);
    data = $urandom();
    data[TL_W-1:0] = tl;
    write_reg(REG_TABLE_LENGTH, data);
    write_reg(REG_MOD_DEPTH, md);
    tab_len_eff = (tl == 0) ? 1 : ((tl > TDEP) ? TDEP : int'(tl));
  endtask

  // every entry the table positions can reach must be loaded before samples
  task automatic fill_table();
    int unsigned a;
    for (a = 0; a < tab_len_eff; a++)
      if (!written[a]) send_load(a, $urandom());
  endtask

  // waits until no word is owed, then a further drain margin
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int               done, r;
    bit               held, drained;
    logic [DL_W-1:0]  dl;
    logic [TL_W-1:0]  tl;
    logic [MD_W-1:0]  md;

    held    = 1'b0;
    drained = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: short delay line, offsets that wrap, half-way fraction
    configure(9'd4, 11'd4, DEPTH_FULL);
    send_load(0, 24'h000000);
    send_load(1, 24'hFFFFFF);
    send_load(2, 24'h018000);
    send_load(3, 24'h020000);
    send_load(TDEP - 1, 24'hFFFFFF);
    send_sample(0, 16'sh7FFF);
    send_sample(0, 16'sh8000);
    send_sample(0, 16'sh7FFF);
    send_sample(0, 16'sh8000);
    send_sample(0, 16'sh0000);
    send_sample(0, -16'sd1);
    send_sample(0, 16'sh7FFF);
    send_sample(1, 16'sh8000);
    send_sample(1, 16'sh7FFF);
    send_sample(MAX_CH, 16'sh1234);
    send_sample(NCH, -16'sd5);
    send_sample(1, 16'sd1);
    send_sample(1, -16'sd1);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: configure(9'd2, 11'd1, 17'd0);
        1: configure(9'd256, 11'd1024, DEPTH_FULL);
        2: begin
          configure(9'd0, 11'd0, 17'h1FFFF);
          write_reg(REG_UNUSED, $urandom());
        end
        3: configure(9'h1FF, 11'h7FF, 17'd1);
        default: begin
          dl = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 256) : $urandom_range(2, 16);
          tl = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 1024)
                                           : $urandom_range(1, 64);
          r = $urandom_range(0, 5);
          md = (r == 0) ? DEPTH_FULL : (r == 1) ? $urandom_range(65537, 131071)
                                                : $urandom_range(0, 65536);
          configure(dl, tl, md);
        end
      endcase
      fill_table();
      quiet = (p == 6 || p == 7);

      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        if (p == 4 && done == 2 && !held) begin
          held = 1'b1;
          hold_req = 1'b1;
        end
        if (p == 5 && done == ITEMS_PER_PHASE / 2 && !drained) begin
          drained = 1'b1;
          in_valid = 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_sample($urandom_range(0, NCH - 1), pick_sample());
          done++;
        end else if (r < 90) begin
          send_load($urandom_range(0, TDEP - 1), $urandom());
          done++;
        end else begin
          // word for an absent channel: ignored by the block
          send_sample($urandom_range(NCH, MAX_CH), pick_sample());
        end
      end
      quiet = 1'b0;
    end

    wait_idle();
    if (errors == 0 && pending == 0)
      $display("tb_vibrato_modulated_delay: clean");
    else
      $display("tb_vibrato_modulated_delay: errors");
    $finish;
  end

endmodule
